/* sv/bur_pkg.sv */
package bur_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int LIMIT_W = 6;
	localparam int KIND_W = 4;
	localparam int PAYLOAD_W = 32;
	localparam int REQ_W = 2;
	localparam int ACTION_W = 3;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd50;

	typedef enum logic [REQ_W-1:0] {
		REQ_RECORD = 2'd0,
		REQ_UNDO   = 2'd1,
		REQ_REDO   = 2'd2
	} req_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE     = 3'd0,
		ACT_UNDO     = 3'd1,
		ACT_REDO     = 3'd2,
		ACT_DISCARD  = 3'd3,
		ACT_RECORDED = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAIL,
		ST_TAIL_OUT,
		ST_EVICT,
		ST_EVICT_OUT,
		ST_REC_OUT,
		ST_MOVE_OUT,
		ST_NONE_OUT
	} state_t;

	typedef enum logic [1:0] {
		OSEL_NONE,
		OSEL_DISC,
		OSEL_MOVE,
		OSEL_REC
	} out_sel_t;

	typedef struct packed {
		logic     accept;
		logic     move;
		logic     tail_rd;
		logic     tail_next;
		logic     trunc;
		logic     evict_rd;
		logic     evict_pop;
		logic     rec_write;
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic cur_nz;
		logic can_redo;
		logic tail_more;
		logic evict_more;
	} dp_stat_t;

endpackage

/* sv/bounded_undo_redo_history.sv */
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     req_type, entry_kind, entry_payload
// out       output     out_valid / out_ready   action, out_kind, out_payload, last_of_run
// cfg       input      cfg_wr_en (no wait)     cfg_wr_data (history_limit)
//
// one transaction in flight at a time; in_ready is high only while idle
// undo, redo and null requests: accept, then a single result, then back to idle
// record: tail discard walk, eviction walk, append, then the recorded result; each discard is one read of the
//   history ram (registered read) followed by its output transaction
// arst_n clears the controller, the ring pointers and sets the limit to 50;
//   ram contents are not cleared, only written entries are ever read
// out_ready low simply holds the current result and the walk
module bounded_undo_redo_history
	import bur_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [KIND_W-1:0]    entry_kind,
	input  logic [PAYLOAD_W-1:0] entry_payload,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ACTION_W-1:0]  action,
	output logic [KIND_W-1:0]    out_kind,
	output logic [PAYLOAD_W-1:0] out_payload,
	output logic                 last_of_run,
	// history limit register
	input  logic                 cfg_wr_en,
	input  logic [LIMIT_W-1:0]   cfg_wr_data
);

	// controller to datapath commands and status back
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: accept, tail discard walk, eviction walk, append, report
	bur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// ring pointers, limit register, history ram and result mux
	bur_datapath #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req_type     (req_type),
		.entry_kind   (entry_kind),
		.entry_payload(entry_payload),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.out_kind     (out_kind),
		.out_payload  (out_payload),
		.last_of_run  (last_of_run)
	);

	// never accepting while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request accepted while a result is pending");

	// a record run always ends on the recorded result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_RECORDED) |-> last_of_run)
		else $error("recorded result not flagged as last of run");

	// the final result of a run returns the controller to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_run |=> in_ready)
		else $error("controller not idle after last result");

	// an accepted undo with history behind the cursor reports that entry next
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_UNDO) && stat.cur_nz |=>
		out_valid && (action == ACT_UNDO))
		else $error("undo did not report the entry at the cursor");

	// a null result carries no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_NONE) |-> (out_kind == '0) && (out_payload == '0))
		else $error("null result carries entry data");

endmodule

/* sv/bur_ram.sv */
module bur_ram #(
	parameter int DATA_W = 36,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/bur_datapath.sv */
module bur_datapath
	import bur_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [LIMIT_W-1:0]   cfg_wr_data,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [KIND_W-1:0]    entry_kind,
	input  logic [PAYLOAD_W-1:0] entry_payload,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic [ACTION_W-1:0]  action,
	output logic [KIND_W-1:0]    out_kind,
	output logic [PAYLOAD_W-1:0] out_payload,
	output logic                 last_of_run
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int DW = KIND_W + PAYLOAD_W;

	logic [LIMIT_W-1:0]   limit_q;
	logic [AW-1:0]        oldest_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        cursor_q;
	logic [CW-1:0]        pos_q;
	logic [REQ_W-1:0]     req_q;
	logic [KIND_W-1:0]    kind_q;
	logic [PAYLOAD_W-1:0] payload_q;

	logic [LW-1:0]        lim_eff;
	logic [CW-1:0]        rd_pos;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 rd_en;
	logic [DW-1:0]        rd_data;

	// ring position to physical slot, sum stays below twice the depth
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
		input logic [CW-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, pos[AW-1:0]};
		if (sum >= (AW+1)'(STORE_DEPTH)) begin
			sum = sum - (AW+1)'(STORE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// effective limit: zero acts as one, clamp to store depth
	always_comb begin
		lim_eff = LW'(limit_q);
		if (limit_q == '0) begin
			lim_eff = LW'(1);
		end
		if (lim_eff > LW'(STORE_DEPTH)) begin
			lim_eff = LW'(STORE_DEPTH);
		end
	end

	assign stat.cur_nz     = (cursor_q != '0);
	assign stat.can_redo   = (cursor_q < count_q);
	assign stat.tail_more  = (pos_q < count_q);
	assign stat.evict_more = (LW'(count_q) >= lim_eff);

	always_comb begin
		rd_pos = pos_q;
		if (cmd.evict_rd) begin
			rd_pos = '0;
		end else if (cmd.move) begin
			rd_pos = (req_type == REQ_UNDO) ? CW'(cursor_q - CW'(1)) : cursor_q;
		end
	end

	assign rd_addr = slot_of(oldest_q, rd_pos);
	assign wr_addr = slot_of(oldest_q, count_q);
	assign rd_en   = cmd.move | cmd.tail_rd | cmd.evict_rd;

	bur_ram #(
		.DATA_W(DW),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.rec_write),
		.wr_addr(wr_addr),
		.wr_data({kind_q, payload_q}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			oldest_q <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			pos_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				pos_q <= cursor_q;
			end else if (cmd.tail_next) begin
				pos_q <= CW'(pos_q + CW'(1));
			end
			if (cmd.move) begin
				if (req_type == REQ_UNDO) begin
					cursor_q <= CW'(cursor_q - CW'(1));
				end else begin
					cursor_q <= CW'(cursor_q + CW'(1));
				end
			end
			if (cmd.trunc) begin
				count_q <= cursor_q;
				if (cursor_q == '0) begin
					oldest_q <= '0;
				end
			end
			if (cmd.evict_pop) begin
				oldest_q <= (oldest_q == AW'(STORE_DEPTH - 1)) ? '0 : AW'(oldest_q + AW'(1));
				count_q  <= CW'(count_q - CW'(1));
			end
			if (cmd.rec_write) begin
				count_q  <= CW'(count_q + CW'(1));
				cursor_q <= CW'(count_q + CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= req_type;
			kind_q    <= entry_kind;
			payload_q <= entry_payload;
		end
	end

	always_comb begin
		case (cmd.out_sel)
			OSEL_DISC: begin
				action      = ACT_DISCARD;
				out_kind    = rd_data[DW-1 -: KIND_W];
				out_payload = rd_data[PAYLOAD_W-1:0];
				last_of_run = 1'b0;
			end
			OSEL_MOVE: begin
				action      = (req_q == REQ_UNDO) ? ACT_UNDO : ACT_REDO;
				out_kind    = rd_data[DW-1 -: KIND_W];
				out_payload = rd_data[PAYLOAD_W-1:0];
				last_of_run = 1'b1;
			end
			OSEL_REC: begin
				action      = ACT_RECORDED;
				out_kind    = kind_q;
				out_payload = payload_q;
				last_of_run = 1'b1;
			end
			default: begin
				action      = ACT_NONE;
				out_kind    = '0;
				out_payload = '0;
				last_of_run = 1'b1;
			end
		endcase
	end

endmodule

/* sv/bur_ctrl.sv */
module bur_ctrl
	import bur_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [REQ_W-1:0] req_type,
	output logic             out_valid,
	input  logic             out_ready,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req_type)
						REQ_RECORD: state_d = ST_TAIL;
						REQ_UNDO:   state_d = stat.cur_nz ? ST_MOVE_OUT : ST_NONE_OUT;
						REQ_REDO:   state_d = stat.can_redo ? ST_MOVE_OUT : ST_NONE_OUT;
						default:    state_d = ST_NONE_OUT;
					endcase
				end
			end
			ST_TAIL:      state_d = stat.tail_more ? ST_TAIL_OUT : ST_EVICT;
			ST_TAIL_OUT:  state_d = out_ready ? ST_TAIL : ST_TAIL_OUT;
			ST_EVICT:     state_d = stat.evict_more ? ST_EVICT_OUT : ST_REC_OUT;
			ST_EVICT_OUT: state_d = out_ready ? ST_EVICT : ST_EVICT_OUT;
			ST_REC_OUT,
			ST_MOVE_OUT,
			ST_NONE_OUT:  state_d = out_ready ? ST_IDLE : state_q;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					cmd.move   = ((req_type == REQ_UNDO) && stat.cur_nz) ||
						((req_type == REQ_REDO) && stat.can_redo);
				end
			end
			ST_TAIL: begin
				cmd.tail_rd = stat.tail_more;
				cmd.trunc   = !stat.tail_more;
			end
			ST_TAIL_OUT: begin
				out_valid     = 1'b1;
				cmd.out_sel   = OSEL_DISC;
				cmd.tail_next = out_ready;
			end
			ST_EVICT: begin
				cmd.evict_rd  = stat.evict_more;
				cmd.rec_write = !stat.evict_more;
			end
			ST_EVICT_OUT: begin
				out_valid     = 1'b1;
				cmd.out_sel   = OSEL_DISC;
				cmd.evict_pop = out_ready;
			end
			ST_REC_OUT: begin
				out_valid   = 1'b1;
				cmd.out_sel = OSEL_REC;
			end
			ST_MOVE_OUT: begin
				out_valid   = 1'b1;
				cmd.out_sel = OSEL_MOVE;
			end
			ST_NONE_OUT: begin
				out_valid   = 1'b1;
				cmd.out_sel = OSEL_NONE;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
